// File: hdl/pcd_pkg.sv
`timescale 1ns / 1ps
// Package for the probabilistic contact detector: widths, register indexes,
// pipeline depth, configuration struct and the normal CDF knot table.
// No dependencies.
package pcd_pkg;

  // Interpolated CDF table size (power of two, 64..4096)
  localparam int CDF_ENTRIES = 1024;
  localparam int CDF_EB      = $clog2(CDF_ENTRIES);
  localparam int IDX_W       = CDF_EB + 1;          // table index 0..CDF_ENTRIES
  localparam int SUB_W       = 15 - CDF_EB;         // bits of s below the table index
  localparam int RSH         = CDF_EB - 6;          // index bits inside one knot segment
  localparam int HALF_E      = CDF_ENTRIES / 2;

  localparam logic [15:0] S_SUB_MASK = 16'((1 << SUB_W) - 1);
  localparam logic [IDX_W-1:0] SEG_MASK = IDX_W'((1 << RSH) - 1);

  // Clamp limit of the standardized value, Q4.12
  localparam int Z_LIMIT = 16384;

  // Register stages from input to output register
  localparam int NST = 8;
  // Stages held inside one CDF lookup unit
  localparam int CDF_ST = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_STANCE_EARLY = 3'd0;
  localparam logic [2:0] REG_STANCE_LATE  = 3'd1;
  localparam logic [2:0] REG_SWING_EARLY  = 3'd2;
  localparam logic [2:0] REG_SWING_LATE   = 3'd3;
  localparam logic [2:0] REG_FORCE_MEAN   = 3'd4;
  localparam logic [2:0] REG_FORCE_INV_SD = 3'd5;
  localparam logic [2:0] REG_FUSION_GAIN  = 3'd6;
  localparam logic [2:0] REG_THRESHOLD    = 3'd7;

  typedef struct packed {
    logic [15:0]        stance_early_inv_sd;
    logic [15:0]        stance_late_inv_sd;
    logic [15:0]        swing_early_inv_sd;
    logic [15:0]        swing_late_inv_sd;
    logic signed [15:0] force_mean;
    logic [15:0]        force_inv_sd;
    logic [15:0]        fusion_gain;
    logic [15:0]        contact_threshold;
  } pcd_cfg_t;

  // round(65536 * Phi(z)), z = 0, 0.125, ..., 4.0
  localparam logic [15:0] CDF_HALF [33] = '{
    16'd32768, 16'd36028, 16'd39237, 16'd42347, 16'd45316, 16'd48104, 16'd50684,
    16'd53033, 16'd55138, 16'd56997, 16'd58612, 16'd59994, 16'd61158, 16'd62123,
    16'd62911, 16'd63544, 16'd64045, 16'd64435, 16'd64735, 16'd64961, 16'd65129,
    16'd65252, 16'd65341, 16'd65404, 16'd65448, 16'd65478, 16'd65498, 16'd65512,
    16'd65521, 16'd65527, 16'd65530, 16'd65533, 16'd65534
  };

  // Knot k covers z = -4 + k/8; indexes above 64 saturate
  function automatic logic [15:0] knot_f(input logic [6:0] k);
    logic [6:0] kk;
    logic [5:0] j;
    kk = (k > 7'd64) ? 7'd64 : k;
    if (kk >= 7'd32) begin
      j = 6'(kk - 7'd32);
      knot_f = CDF_HALF[j];
    end else begin
      j = 6'(7'd32 - kk);
      knot_f = 16'(17'd65536 - {1'b0, CDF_HALF[j]});
    end
  endfunction

endpackage

// File: hdl/probabilistic_contact_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the probabilistic foot contact detector: config registers,
// valid/stall pipeline control. Depends on pcd_pkg, pcd_zcalc, pcd_cdf, pcd_fuse.

// The unit takes one leg sample per cycle while in_stall is low and returns one
// result per sample, in order, after one register stage each for the
// standardization multiply, knot fetch, entry interpolation multiply, entry
// rounding, fraction multiply, CDF rounding, fusion multiply and the output
// register. It keeps no state between samples. Each stage holds a valid bit
// and advances when it is empty or the stage after it advances, so bubbles
// close up and a new sample is taken while a finished result waits under
// out_stall, provided some stage is still empty. Configuration writes are always
// ready and take effect at once; write them only while no sample is in flight.
module probabilistic_contact_detector_unit (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_leg_id,
  input  logic               in_in_stance,
  input  logic [16:0]        in_phase,
  input  logic signed [15:0] in_vertical_force,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_leg_out,
  output logic [15:0]        out_predicted_prob,
  output logic [15:0]        out_measured_prob,
  output logic [15:0]        out_fused_prob,
  output logic               out_in_contact,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NST = pcd_pkg::NST;

  pcd_pkg::pcd_cfg_t cfg_r;

  // Config registers: a transfer writes one register immediately
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stance_early_inv_sd <= 16'd2560;
      cfg_r.stance_late_inv_sd  <= 16'd2560;
      cfg_r.swing_early_inv_sd  <= 16'd2560;
      cfg_r.swing_late_inv_sd   <= 16'd2560;
      cfg_r.force_mean          <= 16'sd240;
      cfg_r.force_inv_sd        <= 16'd410;
      cfg_r.fusion_gain         <= 16'd39322;
      cfg_r.contact_threshold   <= 16'd39322;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcd_pkg::REG_STANCE_EARLY: cfg_r.stance_early_inv_sd <= cfg_data;
        pcd_pkg::REG_STANCE_LATE:  cfg_r.stance_late_inv_sd  <= cfg_data;
        pcd_pkg::REG_SWING_EARLY:  cfg_r.swing_early_inv_sd  <= cfg_data;
        pcd_pkg::REG_SWING_LATE:   cfg_r.swing_late_inv_sd   <= cfg_data;
        pcd_pkg::REG_FORCE_MEAN:   cfg_r.force_mean          <= signed'(cfg_data);
        pcd_pkg::REG_FORCE_INV_SD: cfg_r.force_inv_sd        <= cfg_data;
        pcd_pkg::REG_FUSION_GAIN:  cfg_r.fusion_gain         <= cfg_data;
        pcd_pkg::REG_THRESHOLD:    cfg_r.contact_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control. vld_r[k] marks stage k holding a sample; stage
  // NST-1 is the output register. en[k] loads stage k.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Side band: leg id and the complement flag ride along with the data;
  // the flag is consumed as the CDF result loads the fusion stage
  logic [1:0] leg_r [NST];
  logic       neg_r [NST-2];
  logic       neg_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      leg_r[0] <= in_leg_id;
      neg_r[0] <= neg_nxt;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) leg_r[k] <= leg_r[k-1];
    end
    for (int k = 1; k < NST - 2; k++) begin
      if (en[k]) neg_r[k] <= neg_r[k-1];
    end
  end

  // Stage 0: standardization
  logic [15:0] s_phase, s_force;

  pcd_zcalc u_zcalc (
    .clk            (clk),
    .en             (en[0]),
    .cfg            (cfg_r),
    .in_stance      (in_in_stance),
    .phase          (in_phase),
    .vertical_force (in_vertical_force),
    .s_phase_r      (s_phase),
    .s_force_r      (s_force),
    .neg_nxt        (neg_nxt)
  );

  // Stages 1..5: two CDF lookups in lockstep
  logic [15:0] cdf_phase, cdf_force;

  pcd_cdf u_cdf_phase (
    .clk   (clk),
    .en    (en[pcd_pkg::CDF_ST:1]),
    .s     (s_phase),
    .cdf_r (cdf_phase)
  );

  pcd_cdf u_cdf_force (
    .clk   (clk),
    .en    (en[pcd_pkg::CDF_ST:1]),
    .s     (s_force),
    .cdf_r (cdf_force)
  );

  // Stages 6..7: prediction, fusion and output register
  pcd_fuse u_fuse (
    .clk       (clk),
    .en        (en[NST-1:NST-2]),
    .neg       (neg_r[NST-3]),
    .cdf_phase (cdf_phase),
    .cdf_force (cdf_force),
    .gain      (cfg_r.fusion_gain),
    .threshold (cfg_r.contact_threshold),
    .pred_r    (out_predicted_prob),
    .meas_r    (out_measured_prob),
    .fused_r   (out_fused_prob),
    .contact_r (out_in_contact)
  );

  assign out_leg_out = leg_r[NST-1];

endmodule

// File: hdl/pcd_zcalc.sv
`timescale 1ns / 1ps
// First pipeline stage: standardized phase and force values, clamped and
// offset into table coordinates. Depends on pcd_pkg.
module pcd_zcalc (
  input  logic                  clk,
  input  logic                  en,
  input  pcd_pkg::pcd_cfg_t     cfg,
  input  logic                  in_stance,
  input  logic [16:0]           phase,
  input  logic signed [15:0]    vertical_force,
  output logic [15:0]           s_phase_r,
  output logic [15:0]           s_force_r,
  output logic                  neg_nxt
);

  logic               early;
  logic [15:0]        inv_sd;
  logic signed [17:0] d_ph;
  logic signed [34:0] p_ph;
  logic signed [22:0] z_ph;
  logic signed [16:0] d_fc;
  logic signed [33:0] p_fc;
  logic signed [29:0] z_fc;
  logic [15:0]        s_phase_nxt;
  logic [15:0]        s_force_nxt;

  // Clamp to +-4.0 and shift into 0..32768
  function automatic logic [15:0] to_s(input logic signed [29:0] z);
    logic signed [29:0] zc;
    if (z > 30'sd16384)       zc = 30'sd16384;
    else if (z < -30'sd16384) zc = -30'sd16384;
    else                      zc = z;
    to_s = 16'(zc + 30'sd16384);
  endfunction

  always_comb begin
    early = (phase <= 17'd32768);
    if (in_stance) begin
      inv_sd = early ? cfg.stance_early_inv_sd : cfg.stance_late_inv_sd;
    end else begin
      inv_sd = early ? cfg.swing_early_inv_sd : cfg.swing_late_inv_sd;
    end
    d_ph = early ? signed'({1'b0, phase}) : signed'({1'b0, phase}) - 18'sd65536;
    p_ph = 35'(d_ph) * signed'({19'd0, inv_sd});
    z_ph = 23'((p_ph + 35'sd2048) >>> 12);
    d_fc = 17'(vertical_force) - 17'(cfg.force_mean);
    p_fc = 34'(d_fc) * signed'({18'd0, cfg.force_inv_sd});
    z_fc = 30'((p_fc + 34'sd8) >>> 4);
    s_phase_nxt = to_s(30'(z_ph));
    s_force_nxt = to_s(z_fc);
    // late stance and early swing use the CDF complement
    neg_nxt = (in_stance != early);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_phase_r <= s_phase_nxt;
      s_force_r <= s_force_nxt;
    end
  end

endmodule

// File: hdl/pcd_cdf.sv
`timescale 1ns / 1ps
// Five-stage normal CDF lookup: knot fetch, table-entry interpolation,
// final interpolation between adjacent entries. Depends on pcd_pkg.
module pcd_cdf (
  input  logic                       clk,
  input  logic [pcd_pkg::CDF_ST-1:0] en,
  input  logic [15:0]                s,
  output logic [15:0]                cdf_r
);

  localparam int EB = pcd_pkg::CDF_EB;
  localparam int IW = pcd_pkg::IDX_W;

  // stage A: table index, fraction, knot fetch
  logic [IW-1:0] idx0, idx1;
  logic [6:0]    a0, a1;
  logic [14:0]   f_nxt;
  logic [15:0]   k00, k01, k10, k11;
  logic [EB-1:0] b0_nxt, b1_nxt;
  logic [15:0]   lo0_a_r, lo1_a_r, d0_a_r, d1_a_r;
  logic [EB-1:0] b0_a_r, b1_a_r;
  logic [14:0]   f_a_r;

  always_comb begin
    idx0   = IW'(s >> pcd_pkg::SUB_W);
    idx1   = idx0 + IW'(1);
    f_nxt  = 15'((s & pcd_pkg::S_SUB_MASK) << EB);
    a0     = 7'(idx0 >> pcd_pkg::RSH);
    a1     = 7'(idx1 >> pcd_pkg::RSH);
    b0_nxt = EB'((idx0 & pcd_pkg::SEG_MASK) << 6);
    b1_nxt = EB'((idx1 & pcd_pkg::SEG_MASK) << 6);
    k00    = pcd_pkg::knot_f(a0);
    k01    = pcd_pkg::knot_f(7'(a0 + 7'd1));
    k10    = pcd_pkg::knot_f(a1);
    k11    = pcd_pkg::knot_f(7'(a1 + 7'd1));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lo0_a_r <= k00;
      lo1_a_r <= k10;
      d0_a_r  <= k01 - k00;
      d1_a_r  <= k11 - k10;
      b0_a_r  <= b0_nxt;
      b1_a_r  <= b1_nxt;
      f_a_r   <= f_nxt;
    end
  end

  // stage B: slope times segment offset
  logic [15:0]    lo0_b_r, lo1_b_r;
  logic [EB+15:0] p0_b_r, p1_b_r;
  logic [14:0]    f_b_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lo0_b_r <= lo0_a_r;
      lo1_b_r <= lo1_a_r;
      p0_b_r  <= (EB+16)'(d0_a_r) * (EB+16)'(b0_a_r);
      p1_b_r  <= (EB+16)'(d1_a_r) * (EB+16)'(b1_a_r);
      f_b_r   <= f_a_r;
    end
  end

  // stage C: rounded table entries and their difference
  logic [15:0] r0_nxt, r1_nxt;
  logic [15:0] r0_c_r, dr_c_r;
  logic [14:0] f_c_r;

  always_comb begin
    r0_nxt = lo0_b_r + 16'((p0_b_r + (EB+16)'(pcd_pkg::HALF_E)) >> EB);
    r1_nxt = lo1_b_r + 16'((p1_b_r + (EB+16)'(pcd_pkg::HALF_E)) >> EB);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r0_c_r <= r0_nxt;
      dr_c_r <= r1_nxt - r0_nxt;
      f_c_r  <= f_b_r;
    end
  end

  // stage D: entry slope times fraction
  logic [15:0] r0_d_r;
  logic [30:0] q_d_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r0_d_r <= r0_c_r;
      q_d_r  <= 31'(dr_c_r) * 31'(f_c_r);
    end
  end

  // stage E: rounded result
  always_ff @(posedge clk) begin
    if (en[4]) begin
      cdf_r <= r0_d_r + 16'((q_d_r + 31'd16384) >> 15);
    end
  end

endmodule

// File: hdl/pcd_fuse.sv
`timescale 1ns / 1ps
// Last two stages: gait prediction, fixed-gain fusion, clamp and threshold
// compare into the output register. Depends on pcd_pkg.
module pcd_fuse (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic        neg,
  input  logic [15:0] cdf_phase,
  input  logic [15:0] cdf_force,
  input  logic [15:0] gain,
  input  logic [15:0] threshold,
  output logic [15:0] pred_r,
  output logic [15:0] meas_r,
  output logic [15:0] fused_r,
  output logic        contact_r
);

  logic [15:0]        pred_nxt;
  logic signed [16:0] diff;
  logic [15:0]        pred_m_r, meas_m_r;
  logic signed [33:0] prod_m_r;
  logic signed [17:0] adj;
  logic signed [18:0] sum;
  logic [15:0]        fused_nxt;

  always_comb begin
    pred_nxt = neg ? 16'(17'd65536 - {1'b0, cdf_phase}) : cdf_phase;
    diff     = signed'({1'b0, cdf_force}) - signed'({1'b0, pred_nxt});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pred_m_r <= pred_nxt;
      meas_m_r <= cdf_force;
      prod_m_r <= signed'({18'd0, gain}) * 34'(diff);
    end
  end

  always_comb begin
    adj = 18'((prod_m_r + 34'sd32768) >>> 16);
    sum = signed'({3'd0, pred_m_r}) + 19'(adj);
    if (sum < 19'sd0)          fused_nxt = 16'd0;
    else if (sum > 19'sd65535) fused_nxt = 16'hFFFF;
    else                       fused_nxt = 16'(sum);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pred_r    <= pred_m_r;
      meas_r    <= meas_m_r;
      fused_r   <= fused_nxt;
      contact_r <= (fused_nxt > threshold);
    end
  end

endmodule
